@@ rtl/tcpq_pkg.sv @@
// Shared types, constants and helpers for the two-class priority queue.
`default_nettype none

package tcpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 8;
    localparam int SRV_W       = 8;
    localparam int UNIT_W      = (CNT_W > VAL_W) ? CNT_W : VAL_W;

    localparam logic [VAL_W-1:0] THR_RESET  = 8'd60;
    localparam logic             CMD_INSERT = 1'b0;
    localparam logic             CMD_SERVE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_TAKE_HIGH,
        S_TAKE_LOW,
        S_READ,
        S_DONE
    } t_state;

    // Advance a ring pointer by step (step never above QUEUE_DEPTH), wrapping once.
    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] step);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + (PTR_W + 1)'(step);
        if (sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/two_class_priority_queue_top.sv @@
// Two-class strict-priority queue: two ring stores served under one small sequencer.
`default_nettype none

// Two bounded FIFOs (high and low, QUEUE_DEPTH entries of 8 bits each) share one
// strict-priority server. An insert transfer (command 0) places a nonzero value in
// the high queue when it is strictly above the threshold register, else in the low
// queue; a full target drops the value and flags it. A serve transfer (command 1)
// removes up to value entries, high queue first, then low. Every input transfer
// produces exactly one output transfer with both counts, heads and tails (zero for
// an empty queue), the number served and the drop flag. The comparisons run through
// one shared subtract/compare unit stepped by the sequencer: the threshold test on
// an insert, then the min(remaining, fill) on each queue during a serve. An insert
// passes through the threshold step, the synchronous head read of the stores and the
// result load before ready returns. A serve takes one step per queue in place of the
// single threshold step. The block is not ready while an item is at work. The output
// register lets a finished result wait for its transfer while the next item is
// accepted; the sequencer holds in its last step only if a second result is due
// before the first has left. The user writes the threshold (reset 60) through
// i_cfg_we/i_cfg_wdata only while idle; the block itself does not enforce this.
module two_class_priority_queue_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [tcpq_pkg::VAL_W-1:0]  i_cfg_wdata,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_command,
    input  wire [tcpq_pkg::VAL_W-1:0]  i_value,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [tcpq_pkg::CNT_W-1:0] o_high_count,
    output logic [tcpq_pkg::VAL_W-1:0] o_high_head,
    output logic [tcpq_pkg::VAL_W-1:0] o_high_tail,
    output logic [tcpq_pkg::CNT_W-1:0] o_low_count,
    output logic [tcpq_pkg::VAL_W-1:0] o_low_head,
    output logic [tcpq_pkg::VAL_W-1:0] o_low_tail,
    output logic [tcpq_pkg::SRV_W-1:0] o_served,
    output logic                       o_dropped
);
    import tcpq_pkg::*;

    // Ring stores; contents are never cleared, fill counts guard every read.
    logic [VAL_W-1:0] high_mem [QUEUE_DEPTH];
    logic [VAL_W-1:0] low_mem  [QUEUE_DEPTH];

    t_state           r_state,  n_state;
    logic             r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_thr;
    logic [UNIT_W-1:0] r_rem,   n_rem;
    logic [SRV_W-1:0] r_served, n_served;
    logic             r_dropped, n_dropped;

    logic [PTR_W-1:0] r_high_rd, n_high_rd, r_high_wr, n_high_wr;
    logic [PTR_W-1:0] r_low_rd,  n_low_rd,  r_low_wr,  n_low_wr;
    logic [CNT_W-1:0] r_high_fill, n_high_fill, r_low_fill, n_low_fill;
    logic [VAL_W-1:0] r_high_tail, r_low_tail;
    logic [VAL_W-1:0] r_high_rdata, r_low_rdata;

    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_out_high_count, r_out_low_count;
    logic [VAL_W-1:0] r_out_high_head, r_out_high_tail, r_out_low_head, r_out_low_tail;
    logic [SRV_W-1:0] r_out_served;
    logic             r_out_dropped;

    logic             in_xfer;
    logic             high_push, low_push;
    logic             load_out;

    // Shared unit: one subtractor, borrow doubles as the less-than flag.
    logic [UNIT_W-1:0] unit_a, unit_b, take;
    logic [UNIT_W:0]   unit_diff;
    logic              unit_lt;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        unit_a = r_rem;
        unit_b = UNIT_W'(r_high_fill);
        case (r_state)
            S_INSERT:    begin
                unit_a = UNIT_W'(r_thr);
                unit_b = UNIT_W'(r_val);
            end
            S_TAKE_HIGH: begin
                unit_a = r_rem;
                unit_b = UNIT_W'(r_high_fill);
            end
            S_TAKE_LOW:  begin
                unit_a = r_rem;
                unit_b = UNIT_W'(r_low_fill);
            end
            default:     begin
                unit_a = r_rem;
                unit_b = UNIT_W'(r_high_fill);
            end
        endcase
        unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
        unit_lt   = unit_diff[UNIT_W];
        // min(remaining, fill)
        take      = unit_lt ? unit_a : unit_b;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_served    = r_served;
        n_dropped   = r_dropped;
        n_high_rd   = r_high_rd;
        n_high_wr   = r_high_wr;
        n_low_rd    = r_low_rd;
        n_low_wr    = r_low_wr;
        n_high_fill = r_high_fill;
        n_low_fill  = r_low_fill;
        n_out_valid = r_out_valid && !i_out_ready;
        high_push   = 1'b0;
        low_push    = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_rem     = UNIT_W'(i_value);
                    n_served  = '0;
                    n_dropped = 1'b0;
                    n_state   = (i_command == CMD_SERVE) ? S_TAKE_HIGH : S_INSERT;
                end
            end
            S_INSERT: begin
                // Threshold below value: high queue.
                if (r_val != '0) begin
                    if (unit_lt) begin
                        if (r_high_fill == CNT_W'(QUEUE_DEPTH)) begin
                            n_dropped = 1'b1;
                        end else begin
                            high_push   = 1'b1;
                            n_high_wr   = ptr_adv(r_high_wr, CNT_W'(1));
                            n_high_fill = r_high_fill + CNT_W'(1);
                        end
                    end else begin
                        if (r_low_fill == CNT_W'(QUEUE_DEPTH)) begin
                            n_dropped = 1'b1;
                        end else begin
                            low_push   = 1'b1;
                            n_low_wr   = ptr_adv(r_low_wr, CNT_W'(1));
                            n_low_fill = r_low_fill + CNT_W'(1);
                        end
                    end
                end
                n_state = S_READ;
            end
            S_TAKE_HIGH: begin
                n_high_fill = r_high_fill - CNT_W'(take);
                n_high_rd   = ptr_adv(r_high_rd, CNT_W'(take));
                n_served    = r_served + SRV_W'(take);
                n_rem       = unit_lt ? '0 : unit_diff[UNIT_W-1:0];
                n_state     = S_TAKE_LOW;
            end
            S_TAKE_LOW: begin
                n_low_fill = r_low_fill - CNT_W'(take);
                n_low_rd   = ptr_adv(r_low_rd, CNT_W'(take));
                n_served   = r_served + SRV_W'(take);
                n_rem      = unit_lt ? '0 : unit_diff[UNIT_W-1:0];
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold while the previous result still waits for its transfer.
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_rem       <= '0;
            r_served    <= '0;
            r_dropped   <= 1'b0;
            r_high_rd   <= '0;
            r_high_wr   <= '0;
            r_low_rd    <= '0;
            r_low_wr    <= '0;
            r_high_fill <= '0;
            r_low_fill  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem       <= n_rem;
            r_served    <= n_served;
            r_dropped   <= n_dropped;
            r_high_rd   <= n_high_rd;
            r_high_wr   <= n_high_wr;
            r_low_rd    <= n_low_rd;
            r_low_wr    <= n_low_wr;
            r_high_fill <= n_high_fill;
            r_low_fill  <= n_low_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: captured item, tails, store ports, result.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (high_push) begin
            high_mem[r_high_wr] <= r_val;
            r_high_tail         <= r_val;
        end
        if (low_push) begin
            low_mem[r_low_wr] <= r_val;
            r_low_tail        <= r_val;
        end
        if (r_state == S_READ) begin
            r_high_rdata <= high_mem[r_high_rd];
            r_low_rdata  <= low_mem[r_low_rd];
        end
        if (load_out) begin
            r_out_high_count <= r_high_fill;
            r_out_low_count  <= r_low_fill;
            r_out_high_head  <= (r_high_fill == '0) ? '0 : r_high_rdata;
            r_out_high_tail  <= (r_high_fill == '0) ? '0 : r_high_tail;
            r_out_low_head   <= (r_low_fill == '0) ? '0 : r_low_rdata;
            r_out_low_tail   <= (r_low_fill == '0) ? '0 : r_low_tail;
            r_out_served     <= (r_cmd == CMD_SERVE) ? r_served : '0;
            r_out_dropped    <= (r_cmd == CMD_INSERT) ? r_dropped : 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_high_count = r_out_high_count;
    assign o_high_head  = r_out_high_head;
    assign o_high_tail  = r_out_high_tail;
    assign o_low_count  = r_out_low_count;
    assign o_low_head   = r_out_low_head;
    assign o_low_tail   = r_out_low_tail;
    assign o_served     = r_out_served;
    assign o_dropped    = r_out_dropped;

    // Fill counts never pass the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high_fill <= CNT_W'(QUEUE_DEPTH)) && (r_low_fill <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue fill count beyond depth");

    // A serve never removes more than it asked for.
    a_served_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_SERVE) |-> (r_served <= SRV_W'(r_val)))
        else $error("served count exceeds request");

    // A result appears only from the final sequencer step.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final step");

    // An accepted insert goes to the threshold step next.
    a_insert_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == CMD_INSERT) |=> (r_state == S_INSERT))
        else $error("insert did not enter its step");

    // Fill counts change only while an item is at work.
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($stable(r_high_fill) && $stable(r_low_fill)))
        else $error("fill count moved while idle");

endmodule

`default_nettype wire

@@ dv/two_class_priority_queue_top_tb.sv @@
// Self-checking testbench for two_class_priority_queue_top: directed, burst, random.
module two_class_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpq_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 140;   // with table and burst, about 850 transfers
    localparam int LONG_HOLD     = 300;   // receiver hold-off while the queue backs up
    localparam int SETTLE_CYCLES = 8;     // settle margin after the last status
    localparam int END_WAIT      = 5000;
    localparam int CYCLE_LIMIT   = 600000;

    // One status transfer, in port order.
    typedef struct packed {
        logic [CNT_W-1:0] high_count;
        logic [VAL_W-1:0] high_head;
        logic [VAL_W-1:0] high_tail;
        logic [CNT_W-1:0] low_count;
        logic [VAL_W-1:0] low_head;
        logic [VAL_W-1:0] low_tail;
        logic [SRV_W-1:0] served;
        logic             dropped;
    } status_t;

    // Directed row: an item, plus a typed-in status where it is obvious by eye.
    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] val;
        logic             typed;
        status_t          exp;
    } stim_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [VAL_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_command;
    logic [VAL_W-1:0] i_value;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [CNT_W-1:0] o_high_count;
    logic [VAL_W-1:0] o_high_head;
    logic [VAL_W-1:0] o_high_tail;
    logic [CNT_W-1:0] o_low_count;
    logic [VAL_W-1:0] o_low_head;
    logic [VAL_W-1:0] o_low_tail;
    logic [SRV_W-1:0] o_served;
    logic             o_dropped;

    // Predictor state: our own copy of both rings and of the threshold register.
    logic [VAL_W-1:0] high_ring[$];
    logic [VAL_W-1:0] low_ring[$];
    logic [VAL_W-1:0] threshold_copy;

    // Statuses owed by the block, oldest first.
    status_t pending_status[$];
    status_t seen_status;
    status_t want_status;

    int unsigned cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int inserts_sent = 0;
    int serves_sent = 0;
    int drops_seen = 0;
    int high_peak = 0;
    int low_peak = 0;
    bit long_hold_req = 1'b0;

    two_class_priority_queue_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_high_count (o_high_count),
        .o_high_head  (o_high_head),
        .o_high_tail  (o_high_tail),
        .o_low_count  (o_low_count),
        .o_low_head   (o_low_head),
        .o_low_tail   (o_low_tail),
        .o_served     (o_served),
        .o_dropped    (o_dropped)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d statuses outstanding",
                     $time, cycle_count, pending_status.size());
            $display("[two_class_priority_queue_top] ERROR");
            $finish;
        end
    end

    // Apply one item to the predictor copy and return the status it must produce.
    // Inserts of zero change nothing; a full target ring drops the value;
    // a serve drains high first, then low, and stops after val entries or once both are empty.
    function automatic status_t predict_status(input logic cmd, input logic [VAL_W-1:0] val);
        status_t s;
        int taken;
        s = '0;
        taken = 0;
        if (cmd == CMD_INSERT) begin
            if (val != '0) begin
                if (val > threshold_copy) begin
                    if (high_ring.size() >= QUEUE_DEPTH) s.dropped = 1'b1;
                    else high_ring.push_back(val);
                end else begin
                    if (low_ring.size() >= QUEUE_DEPTH) s.dropped = 1'b1;
                    else low_ring.push_back(val);
                end
            end
        end else begin
            while (taken < int'(val) && (high_ring.size() + low_ring.size()) > 0) begin
                if (high_ring.size() > 0) void'(high_ring.pop_front());
                else void'(low_ring.pop_front());
                taken++;
            end
        end
        s.served     = SRV_W'(taken);
        s.high_count = CNT_W'(high_ring.size());
        s.low_count  = CNT_W'(low_ring.size());
        if (high_ring.size() > 0) begin
            s.high_head = high_ring[0];
            s.high_tail = high_ring[$];
        end
        if (low_ring.size() > 0) begin
            s.low_head = low_ring[0];
            s.low_tail = low_ring[$];
        end
        if (high_ring.size() > high_peak) high_peak = high_ring.size();
        if (low_ring.size() > low_peak) low_peak = low_ring.size();
        return s;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: status #%0d %s expected %0d, got %0d",
                     $time, results_checked, name, want, got);
        end
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item and hold it until the transfer; predict on acceptance.
    // Valid stays high on return so back-to-back items need no extra NBA.
    task automatic send_item(input logic cmd, input logic [VAL_W-1:0] val,
                             input logic use_typed, input status_t typed);
        status_t predicted;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_status(cmd, val);
        pending_status.push_back(use_typed ? typed : predicted);
        if (cmd == CMD_INSERT) inserts_sent++;
        else serves_sent++;
    endtask

    task automatic pause_input(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed status has been seen, then settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the threshold only once the block is idle.
    task automatic write_threshold(input logic [VAL_W-1:0] thr);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        threshold_copy = thr;
    endtask

    // Output checker: compare every status transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_status = '{o_high_count, o_high_head, o_high_tail, o_low_count,
                            o_low_head, o_low_tail, o_served, o_dropped};
            if (pending_status.size() == 0) begin
                mismatches++;
                $display("%0t ns: status transfer with nothing expected, got %p",
                         $time, seen_status);
            end else begin
                want_status = pending_status.pop_front();
                check_field("high_count", int'(want_status.high_count),
                            int'(seen_status.high_count));
                check_field("high_head",  int'(want_status.high_head),
                            int'(seen_status.high_head));
                check_field("high_tail",  int'(want_status.high_tail),
                            int'(seen_status.high_tail));
                check_field("low_count",  int'(want_status.low_count),
                            int'(seen_status.low_count));
                check_field("low_head",   int'(want_status.low_head),
                            int'(seen_status.low_head));
                check_field("low_tail",   int'(want_status.low_tail),
                            int'(seen_status.low_tail));
                check_field("served",     int'(want_status.served),
                            int'(seen_status.served));
                check_field("dropped",    int'(want_status.dropped),
                            int'(seen_status.dropped));
            end
            if (seen_status.dropped) drops_seen++;
            results_checked++;
        end
    end

    // Receiver: random ready with short and long stalls, long no-stall runs,
    // and one long hold-off on request so the block backs up and stalls its input.
    initial begin
        int run_len;
        int gap_len;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                     : $urandom_range(30, 120);
                repeat (run_len) @(posedge i_clk);
                gap_len = pick_gap();
                if (gap_len > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap_len) @(posedge i_clk);
                end
            end
        end
    end

    // Sender: reset, directed table, full-queue burst, then random phases.
    initial begin
        stim_row_t        rows[$];
        logic [VAL_W-1:0] thr_plan[PHASES];
        int               insert_pct[PHASES];
        int               counted;
        int               burst_left;
        int               pick;
        int               end_wait;
        logic             cmd;
        logic [VAL_W-1:0] val;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_command   <= CMD_INSERT;
        i_value     <= '0;
        threshold_copy = THR_RESET;

        // Threshold 60 from reset. Typed-in rows are the obvious ones:
        // serve of zero, serve beyond empty contents, zero inserts,
        // both value extremes, and the values right at and above threshold.
        rows = '{
            '{CMD_SERVE,  8'd0,   1'b1, '{7'd0, 8'd0,   8'd0,  7'd0, 8'd0, 8'd0,  8'd0, 1'b0}},
            '{CMD_SERVE,  8'd255, 1'b1, '{7'd0, 8'd0,   8'd0,  7'd0, 8'd0, 8'd0,  8'd0, 1'b0}},
            '{CMD_INSERT, 8'd0,   1'b1, '{7'd0, 8'd0,   8'd0,  7'd0, 8'd0, 8'd0,  8'd0, 1'b0}},
            '{CMD_INSERT, 8'd255, 1'b1, '{7'd1, 8'd255, 8'd255, 7'd0, 8'd0, 8'd0,  8'd0, 1'b0}},
            '{CMD_INSERT, 8'd1,   1'b1, '{7'd1, 8'd255, 8'd255, 7'd1, 8'd1, 8'd1,  8'd0, 1'b0}},
            '{CMD_INSERT, 8'd60,  1'b1, '{7'd1, 8'd255, 8'd255, 7'd2, 8'd1, 8'd60, 8'd0, 1'b0}},
            '{CMD_INSERT, 8'd61,  1'b1, '{7'd2, 8'd255, 8'd61,  7'd2, 8'd1, 8'd60, 8'd0, 1'b0}},
            '{CMD_INSERT, 8'd0,   1'b1, '{7'd2, 8'd255, 8'd61,  7'd2, 8'd1, 8'd60, 8'd0, 1'b0}},
            '{CMD_INSERT, 8'hAA,  1'b0, '0},
            '{CMD_INSERT, 8'h55,  1'b0, '0},
            '{CMD_INSERT, 8'h80,  1'b0, '0},
            '{CMD_INSERT, 8'h7F,  1'b0, '0},
            '{CMD_SERVE,  8'd1,   1'b0, '0},
            '{CMD_SERVE,  8'd4,   1'b0, '0},
            '{CMD_SERVE,  8'd0,   1'b0, '0},
            '{CMD_SERVE,  8'hFF,  1'b0, '0}
        };

        // Phase plan: both threshold extremes, reset value, random middles;
        // insert-heavy phases push the rings to full and wrap the pointers.
        thr_plan   = '{8'd0, 8'd255, THR_RESET, 8'($urandom_range(1, 254)),
                       8'($urandom_range(1, 254))};
        insert_pct = '{95, 92, 70, 85, 60};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table back to back.
        foreach (rows[r]) send_item(rows[r].cmd, rows[r].val, rows[r].typed, rows[r].exp);

        // Fill both rings past full while the receiver holds off: the output
        // register backs up and the block stalls its input. Two overflow inserts
        // per class must come back dropped; the final serve takes all 128.
        drain_results();
        long_hold_req = 1'b1;
        repeat (QUEUE_DEPTH + 2)
            send_item(CMD_INSERT, 8'($urandom_range(int'(THR_RESET) + 1, 255)), 1'b0, '0);
        repeat (QUEUE_DEPTH + 2)
            send_item(CMD_INSERT, 8'($urandom_range(1, int'(THR_RESET))), 1'b0, '0);
        send_item(CMD_SERVE, 8'd255, 1'b1,
                  '{7'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd128, 1'b0});

        // Random phases, each under its own threshold.
        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_threshold(thr_plan[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // Open a no-idle stretch now and then; else take a random gap.
                if (burst_left == 0 && $urandom_range(0, 49) == 0)
                    burst_left = $urandom_range(20, 60);
                if (burst_left > 0) burst_left--;
                else pause_input(pick_gap());

                if ($urandom_range(0, 99) < insert_pct[ph]) begin
                    cmd = CMD_INSERT;
                    val = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                end else begin
                    cmd  = CMD_SERVE;
                    pick = $urandom_range(0, 39);
                    if (pick < 30) val = 8'($urandom_range(0, 3));
                    else if (pick < 39) val = 8'($urandom_range(4, 20));
                    else val = 8'($urandom_range(21, 255));
                end
                send_item(cmd, val, 1'b0, '0);

                // Zero inserts are ignored by the block; do not count them.
                if (!(cmd == CMD_INSERT && val == '0)) counted++;

                // Hold the sender once mid-phase until everything is back.
                if (ph == 2 && counted == PHASE_ITEMS / 2) drain_results();
            end
        end

        // Stop offering, wait out the owed statuses, then let the pipe settle.
        i_in_valid <= 1'b0;
        end_wait = 0;
        while (pending_status.size() != 0 && end_wait < END_WAIT) begin
            @(posedge i_clk);
            end_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            mismatches += pending_status.size();
            $display("%0t ns: %0d expected statuses never arrived",
                     $time, pending_status.size());
        end

        $display("Covered %0d inserts and %0d serves: table, full-ring burst, five phases; %0d drops,",
                 inserts_sent, serves_sent, drops_seen);
        $display("ring peaks high %0d / low %0d; %0d statuses checked, %0d mismatches.",
                 high_peak, low_peak, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("[two_class_priority_queue_top] OK");
        end else begin
            $display("[two_class_priority_queue_top] ERROR");
        end
        $finish;
    end

endmodule
